@@ sv/vdf_pkg.sv @@
`timescale 1ns / 1ps

package vdf_pkg;

  localparam int DIST_W = 8;
  localparam logic [DIST_W-1:0] NO_SOLID = 8'd255;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_READ,
    S_WR_WRITE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIST_W-1:0] dx;
    logic [DIST_W-1:0] dy;
    logic [DIST_W-1:0] dz;
  } eval_t;

endpackage

@@ sv/vdf_ram.sv @@
`timescale 1ns / 1ps

module vdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ sv/vdf_row_eval.sv @@
`timescale 1ns / 1ps

module vdf_row_eval #(
  parameter int MAX_DIM = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [MAX_DIM-1:0]            row_i,
  input  logic [$clog2(MAX_DIM)-1:0]    exm1_i,
  input  logic [4:0]                    x_i,
  input  logic [vdf_pkg::DIST_W-1:0]    dy_i,
  input  logic [vdf_pkg::DIST_W-1:0]    dz_i,
  output vdf_pkg::eval_t                ev_o
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = vdf_pkg::DIST_W;

  logic [DW-1:0] x8;
  logic          lo_found;
  logic          hi_found;
  logic [DW-1:0] lo_idx;
  logic [DW-1:0] hi_idx;
  logic [DW-1:0] dx_lo;
  logic [DW-1:0] dx_hi;
  logic [DW-1:0] dx_d;

  logic          valid_q;
  logic          found_q;
  logic [DW-1:0] dx_q;
  logic [DW-1:0] dy_q;
  logic [DW-1:0] dz_q;

  assign x8 = DW'(x_i);

  // nearest solid at or below x, and nearest solid above x
  always_comb begin
    lo_found = 1'b0;
    lo_idx   = '0;
    hi_found = 1'b0;
    hi_idx   = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (row_i[i] && (IW'(i) <= exm1_i) && (DW'(i) <= x8)) begin
        lo_found = 1'b1;
        lo_idx   = DW'(i);
      end
    end
    for (int i = MAX_DIM - 1; i >= 0; i--) begin
      if (row_i[i] && (IW'(i) <= exm1_i) && (DW'(i) > x8)) begin
        hi_found = 1'b1;
        hi_idx   = DW'(i);
      end
    end
  end

  assign dx_lo = x8 - lo_idx;
  assign dx_hi = hi_idx - x8;

  always_comb begin
    if (!lo_found) begin
      dx_d = dx_hi;
    end else if (!hi_found) begin
      dx_d = dx_lo;
    end else if (dx_hi < dx_lo) begin
      dx_d = dx_hi;
    end else begin
      dx_d = dx_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= lo_found | hi_found;
    dx_q    <= dx_d;
    dy_q    <= dy_i;
    dz_q    <= dz_i;
  end

  assign ev_o.valid = valid_q;
  assign ev_o.found = found_q;
  assign ev_o.dx    = dx_q;
  assign ev_o.dy    = dy_q;
  assign ev_o.dz    = dz_q;

endmodule

@@ sv/voxel_distance_field.sv @@
`timescale 1ns / 1ps

// Voxel occupancy grid with distance queries.
// Input channel (in_valid_i / in_ready_o) carries one item: op_i selects a
// write (solid_in_i sets or clears the voxel at coord_*_i) or a query.
// Writes outside the active extent are dropped; writes give no result.
// Each query gives one result item on the output channel (out_valid_o /
// out_ready_i): Manhattan and Chebyshev distance to the nearest solid voxel
// inside the extent (255 when there is none) and the voxel's own solid flag.
// A write reads its x row and writes it back modified. A query scans each
// row of the extent: the occupancy memory holds one x row per word and the
// scan reads one row per cycle through a shared nearest-in-row unit.
// After reset the grid is cleared, one row per cycle, for all MAX_DIM *
// MAX_DIM rows (1024 by default) with in_ready_o low; the APB port works meanwhile.
// A finished result waits in the output register while the block takes the
// next item; a query that ends while that register is still full holds until
// the receiver takes the older result. The extent registers reset to 32.
module voxel_distance_field #(
  parameter int MAX_DIM = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [4:0]  coord_x_i,
  input  logic [4:0]  coord_y_i,
  input  logic [4:0]  coord_z_i,
  input  logic        solid_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  manhattan_dist_o,
  output logic [7:0]  chebyshev_dist_o,
  output logic        solid_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = vdf_pkg::DIST_W;

  vdf_pkg::state_e state_q, state_d;

  logic [5:0] size_x_q, size_y_q, size_z_q;
  logic [IW-1:0] exm1, eym1, ezm1;
  logic       cfg_we;

  logic [AW-1:0] clr_cnt_q;
  logic [IW-1:0] sy_q, sy_d;
  logic [IW-1:0] sz_q, sz_d;
  logic       scan_last;

  logic [4:0] req_x_q, req_y_q, req_z_q;
  logic       req_solid_q;

  logic       in_accept;
  logic       in_inside;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MAX_DIM-1:0] ram_wdata, ram_rdata, row_mod;
  logic [AW-1:0] req_addr, scan_addr;

  logic          p1_valid_q;
  logic [DW-1:0] p1_dy_q, p1_dz_q;
  logic [DW-1:0] dy_d, dz_d;
  vdf_pkg::eval_t ev;

  logic [DW+1:0] d1;
  logic [DW-1:0] dm;
  logic [DW-1:0] l1_q, linf_q;
  logic          solid_q;

  logic          out_load;
  logic          out_valid_q;
  logic [DW-1:0] res_l1_q, res_linf_q;
  logic          res_solid_q;

  function automatic logic [IW-1:0] ext_m1(input logic [5:0] r);
    if (r == 6'd0) begin
      ext_m1 = '0;
    end else if (9'(r) > 9'(MAX_DIM)) begin
      ext_m1 = IW'(MAX_DIM - 1);
    end else begin
      ext_m1 = IW'(r - 6'd1);
    end
  endfunction

  function automatic logic [AW-1:0] row_addr(input logic [IW-1:0] z,
                                              input logic [IW-1:0] y);
    row_addr = AW'(z) * AW'(MAX_DIM) + AW'(y);
  endfunction

  function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a,
                                              input logic [DW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 6'd32;
      size_y_q <= 6'd32;
      size_z_q <= 6'd32;
    end else if (cfg_we) begin
      case (paddr[3:2])
        vdf_pkg::REG_SIZE_X: size_x_q <= pwdata[5:0];
        vdf_pkg::REG_SIZE_Y: size_y_q <= pwdata[5:0];
        vdf_pkg::REG_SIZE_Z: size_z_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vdf_pkg::REG_SIZE_X: prdata = 32'(size_x_q);
      vdf_pkg::REG_SIZE_Y: prdata = 32'(size_y_q);
      vdf_pkg::REG_SIZE_Z: prdata = 32'(size_z_q);
      default:             prdata = '0;
    endcase
  end

  assign exm1 = ext_m1(size_x_q);
  assign eym1 = ext_m1(size_y_q);
  assign ezm1 = ext_m1(size_z_q);

  // input handshake
  assign in_ready_o = (state_q == vdf_pkg::S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_inside  = (DW'(coord_x_i) <= DW'(exm1)) && (DW'(coord_y_i) <= DW'(eym1))
                   && (DW'(coord_z_i) <= DW'(ezm1));

  assign scan_last = (sy_q == eym1) && (sz_q == ezm1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vdf_pkg::S_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = vdf_pkg::S_IDLE;
        end
      end
      vdf_pkg::S_IDLE: begin
        if (in_accept) begin
          if (op_i == vdf_pkg::OP_QUERY) begin
            state_d = vdf_pkg::S_SCAN;
          end else if (in_inside) begin
            state_d = vdf_pkg::S_WR_READ;
          end
        end
      end
      vdf_pkg::S_WR_READ:  state_d = vdf_pkg::S_WR_WRITE;
      vdf_pkg::S_WR_WRITE: state_d = vdf_pkg::S_IDLE;
      vdf_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = vdf_pkg::S_DRAIN;
        end
      end
      vdf_pkg::S_DRAIN: begin
        if (!p1_valid_q && !ev.valid) begin
          state_d = vdf_pkg::S_DONE;
        end
      end
      vdf_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = vdf_pkg::S_IDLE;
        end
      end
      default: state_d = vdf_pkg::S_IDLE;
    endcase
  end

  // memory control
  assign req_addr  = row_addr(IW'(req_z_q), IW'(req_y_q));
  assign scan_addr = row_addr(sz_q, sy_q);

  always_comb begin
    row_mod = ram_rdata;
    row_mod[IW'(req_x_q)] = req_solid_q;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_addr;
    ram_wdata = row_mod;
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    out_load  = 1'b0;
    case (state_q)
      vdf_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      vdf_pkg::S_WR_READ: begin
        ram_re    = 1'b1;
        ram_raddr = req_addr;
      end
      vdf_pkg::S_WR_WRITE: begin
        ram_we = 1'b1;
      end
      vdf_pkg::S_SCAN: begin
        ram_re = 1'b1;
      end
      vdf_pkg::S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  vdf_ram #(
    .WIDTH (MAX_DIM),
    .DEPTH (DEPTH)
  ) u_vdf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scan counters
  always_comb begin
    sy_d = sy_q;
    sz_d = sz_q;
    if (in_accept) begin
      sy_d = '0;
      sz_d = '0;
    end else if (state_q == vdf_pkg::S_SCAN) begin
      if (sy_q == eym1) begin
        sy_d = '0;
        sz_d = sz_q + 1'b1;
      end else begin
        sy_d = sy_q + 1'b1;
      end
    end
  end

  assign dy_d = abs_diff(DW'(req_y_q), DW'(sy_q));
  assign dz_d = abs_diff(DW'(req_z_q), DW'(sz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdf_pkg::S_CLEAR;
      clr_cnt_q   <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sy_q        <= sy_d;
      sz_q        <= sz_d;
      p1_valid_q  <= (state_q == vdf_pkg::S_SCAN);
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (state_q == vdf_pkg::S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  vdf_row_eval #(
    .MAX_DIM (MAX_DIM)
  ) u_vdf_row_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid_q),
    .row_i   (ram_rdata),
    .exm1_i  (exm1),
    .x_i     (req_x_q),
    .dy_i    (p1_dy_q),
    .dz_i    (p1_dz_q),
    .ev_o    (ev)
  );

  assign d1 = (DW+2)'(ev.dx) + (DW+2)'(ev.dy) + (DW+2)'(ev.dz);

  always_comb begin
    dm = (ev.dx > ev.dy) ? ev.dx : ev.dy;
    if (ev.dz > dm) begin
      dm = ev.dz;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p1_dy_q <= dy_d;
    p1_dz_q <= dz_d;
    if (in_accept) begin
      req_x_q     <= coord_x_i;
      req_y_q     <= coord_y_i;
      req_z_q     <= coord_z_i;
      req_solid_q <= solid_in_i;
      l1_q        <= vdf_pkg::NO_SOLID;
      linf_q      <= vdf_pkg::NO_SOLID;
      solid_q     <= 1'b0;
    end else if (ev.valid && ev.found) begin
      if (d1 < (DW+2)'(l1_q)) begin
        l1_q <= d1[DW-1:0];
      end
      if (dm < linf_q) begin
        linf_q <= dm;
      end
      if ((ev.dx == '0) && (ev.dy == '0) && (ev.dz == '0)) begin
        solid_q <= 1'b1;
      end
    end
    if (out_load) begin
      res_l1_q    <= l1_q;
      res_linf_q  <= linf_q;
      res_solid_q <= solid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign manhattan_dist_o = res_l1_q;
  assign chebyshev_dist_o = res_linf_q;
  assign solid_out_o      = res_solid_q;

endmodule

@@ sv/vdf_checker.sv @@
`timescale 1ns / 1ps

module vdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       op_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] manhattan_dist_o,
  input logic [7:0] chebyshev_dist_o,
  input logic       solid_out_o
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(manhattan_dist_o)
        && $stable(chebyshev_dist_o) && $stable(solid_out_o);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

  property p_solid_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && solid_out_o |-> manhattan_dist_o == 8'd0 && chebyshev_dist_o == 8'd0;
  endproperty
  a_solid_zero: assert property (p_solid_zero) else $error("solid voxel with nonzero distance");

  property p_cheb_le_manh;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> chebyshev_dist_o <= manhattan_dist_o
        && {2'b00, manhattan_dist_o} <= 10'd3 * {2'b00, chebyshev_dist_o};
  endproperty
  a_cheb_le_manh: assert property (p_cheb_le_manh) else $error("distance pair inconsistent");

  property p_query_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && op_i == vdf_pkg::OP_QUERY |=> !in_ready_o;
  endproperty
  a_query_busy: assert property (p_query_busy) else $error("ready during a query scan");

endmodule

bind voxel_distance_field vdf_checker u_vdf_checker (.*);
